// ----- sv/se2pt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// se2pt_pkg
// Shared types and constants of the se2 pose transform: trig cache format,
// quarter-wave sine coefficients and register indexes.
// ----------------------------------------------------------------------------
package se2pt_pkg;

   // Q1.16 trig values, range -1.0 .. +1.0
   localparam int TRIG_W   = 18;
   localparam int FRAC_W   = 16;
   localparam int TRIG_MAG_W = 17;
   localparam logic [TRIG_MAG_W-1:0] TRIG_ONE = 17'd65536;

   // Q30 quarter-wave sine polynomial, odd terms
   localparam int Q30_W  = 30;
   localparam int POLY_W = 31;
   localparam logic [POLY_W-1:0] SC1 = 31'd1686629713;
   localparam logic [POLY_W-1:0] SC3 = 31'd693598668;
   localparam logic [POLY_W-1:0] SC5 = 31'd85569306;
   localparam logic [POLY_W-1:0] SC7 = 31'd5026995;
   localparam logic [POLY_W-1:0] SC9 = 31'd172272;
   localparam logic [POLY_W-1:0] Q30_ONE = 31'd1073741824;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_POSE_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSE_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POSE_HEADING = 2'd2;

   typedef struct packed {
      logic                     busy;
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } trig_type;

endpackage

// ----- sv/se2pt_trig.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// se2pt_trig
// Sine and cosine of the heading. One shared 31x31 multiplier runs the
// Horner chain for S(r) and then S(1 - r), one product per cycle.
// ----------------------------------------------------------------------------
module se2pt_trig #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ANGLE_WIDTH-1:0] heading,
   output se2pt_pkg::trig_type    trig
);

   localparam int PROD_W = 2 * se2pt_pkg::POLY_W;
   localparam int PAD_W  = se2pt_pkg::Q30_W - (ANGLE_WIDTH - 2);

   localparam logic [2:0] STEP_SQUARE = 3'd0;
   localparam logic [2:0] STEP_C7     = 3'd1;
   localparam logic [2:0] STEP_C5     = 3'd2;
   localparam logic [2:0] STEP_C3     = 3'd3;
   localparam logic [2:0] STEP_C1     = 3'd4;
   localparam logic [2:0] STEP_FINAL  = 3'd5;

   typedef enum logic {
      TRIG_IDLE,
      TRIG_RUN
   } state_type;

   state_type                                state_ff;
   logic [2:0]                               step_ff;
   logic                                     pass_ff;
   logic [1:0]                               quad_ff;
   logic [se2pt_pkg::Q30_W-1:0]              r_ff;
   logic [se2pt_pkg::POLY_W-1:0]             u_ff;
   logic [se2pt_pkg::POLY_W-1:0]             x2_ff;
   logic [se2pt_pkg::POLY_W-1:0]             p_ff;
   logic [se2pt_pkg::TRIG_MAG_W-1:0]         a_ff;
   logic signed [se2pt_pkg::TRIG_W-1:0]      sin_ff;
   logic signed [se2pt_pkg::TRIG_W-1:0]      cos_ff;

   logic [se2pt_pkg::POLY_W-1:0]             mul_a;
   logic [se2pt_pkg::POLY_W-1:0]             mul_b;
   logic [PROD_W-1:0]                        prod;
   logic [31:0]                              prod_hi;
   logic [se2pt_pkg::POLY_W-1:0]             coef;
   logic [se2pt_pkg::POLY_W-1:0]             p_in;
   logic [32:0]                              rnd;
   logic [se2pt_pkg::TRIG_MAG_W-1:0]         res_in;
   logic [se2pt_pkg::Q30_W-1:0]              r_in;
   logic signed [se2pt_pkg::TRIG_W-1:0]      pos_a;
   logic signed [se2pt_pkg::TRIG_W-1:0]      pos_b;

   assign r_in = {heading[ANGLE_WIDTH-3:0], {PAD_W{1'b0}}};

   always_comb begin
      case (step_ff)
         STEP_SQUARE: begin
            mul_a = u_ff;
            mul_b = u_ff;
         end
         STEP_C7: begin
            mul_a = se2pt_pkg::SC9;
            mul_b = x2_ff;
         end
         STEP_FINAL: begin
            mul_a = u_ff;
            mul_b = p_ff;
         end
         default: begin
            mul_a = p_ff;
            mul_b = x2_ff;
         end
      endcase
   end

   always_comb begin
      case (step_ff)
         STEP_C7: coef = se2pt_pkg::SC7;
         STEP_C5: coef = se2pt_pkg::SC5;
         STEP_C3: coef = se2pt_pkg::SC3;
         default: coef = se2pt_pkg::SC1;
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign prod_hi = prod[PROD_W-1:se2pt_pkg::Q30_W];
   assign p_in    = se2pt_pkg::POLY_W'({1'b0, coef} - prod_hi);
   // round Q30 to Q16 half up, then clamp to one
   assign rnd     = {1'b0, prod_hi} + 33'd8192;
   assign res_in  = (rnd[32:14] > {2'b00, se2pt_pkg::TRIG_ONE}) ? se2pt_pkg::TRIG_ONE
                                                                 : rnd[30:14];
   assign pos_a   = {1'b0, a_ff};
   assign pos_b   = {1'b0, res_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TRIG_IDLE;
         step_ff  <= STEP_SQUARE;
         pass_ff  <= 1'b0;
         sin_ff   <= '0;
         cos_ff   <= se2pt_pkg::TRIG_W'(se2pt_pkg::TRIG_ONE);
      end else begin
         case (state_ff)
            TRIG_IDLE: begin
               if (start) begin
                  state_ff <= TRIG_RUN;
                  step_ff  <= STEP_SQUARE;
                  pass_ff  <= 1'b0;
               end
            end
            TRIG_RUN: begin
               if (step_ff == STEP_FINAL) begin
                  step_ff <= STEP_SQUARE;
                  if (pass_ff) begin
                     state_ff <= TRIG_IDLE;
                     case (quad_ff)
                        2'd0: begin
                           sin_ff <= pos_a;
                           cos_ff <= pos_b;
                        end
                        2'd1: begin
                           sin_ff <= pos_b;
                           cos_ff <= -pos_a;
                        end
                        2'd2: begin
                           sin_ff <= -pos_a;
                           cos_ff <= -pos_b;
                        end
                        default: begin
                           sin_ff <= -pos_b;
                           cos_ff <= pos_a;
                        end
                     endcase
                  end else begin
                     pass_ff <= 1'b1;
                  end
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            default: state_ff <= TRIG_IDLE;
         endcase
      end
   end

   // datapath of the horner chain
   always_ff @(posedge clock) begin
      if (state_ff == TRIG_IDLE) begin
         if (start) begin
            quad_ff <= heading[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
            r_ff    <= r_in;
            u_ff    <= {1'b0, r_in};
         end
      end else begin
         case (step_ff)
            STEP_SQUARE: x2_ff <= prod_hi[se2pt_pkg::POLY_W-1:0];
            STEP_FINAL: begin
               // second pass runs on the complementary angle
               a_ff <= res_in;
               u_ff <= se2pt_pkg::Q30_ONE - {1'b0, r_ff};
            end
            default: p_ff <= p_in;
         endcase
      end
   end

   assign trig.busy    = (state_ff == TRIG_RUN);
   assign trig.sin_val = sin_ff;
   assign trig.cos_val = cos_ff;

endmodule

// ----- sv/se2pt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// se2pt_datapath
// Four-stage transform pipeline: input register, rotation products,
// rounded rotation sums, translation with saturation.
// ----------------------------------------------------------------------------
module se2pt_datapath #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic [ANGLE_WIDTH-1:0]        in_angle,
   input  logic signed [COORD_WIDTH-1:0] pose_x,
   input  logic signed [COORD_WIDTH-1:0] pose_y,
   input  logic [ANGLE_WIDTH-1:0]        pose_heading,
   input  se2pt_pkg::trig_type           trig,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_x,
   output logic signed [COORD_WIDTH-1:0] out_y,
   output logic [ANGLE_WIDTH-1:0]        out_angle,
   output logic                          saturated
);

   localparam int PW  = COORD_WIDTH + se2pt_pkg::TRIG_W;
   localparam int RW  = PW + 1 - se2pt_pkg::FRAC_W;
   localparam int SW  = RW + 1;
   localparam logic signed [PW:0] ROUND_HALF = (PW + 1)'(1) <<< (se2pt_pkg::FRAC_W - 1);
   localparam logic signed [SW-1:0] COORD_MAX = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SW-1:0] COORD_MIN = -COORD_MAX - SW'(1);

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic rdy0, rdy1, rdy2, rdy3;

   logic signed [COORD_WIDTH-1:0] x0_ff, y0_ff;
   logic [ANGLE_WIDTH-1:0]        a0_ff, a1_ff, a2_ff, a3_ff;
   logic signed [PW-1:0]          cx_ff, sy_ff, sx_ff, cy_ff;
   logic signed [PW-1:0]          cx_in, sy_in, sx_in, cy_in;
   logic signed [PW:0]            rx_sum, ry_sum;
   logic signed [RW-1:0]          rx_ff, ry_ff;
   logic signed [SW-1:0]          tx_sum, ty_sum;
   logic signed [COORD_WIDTH-1:0] ox_ff, oy_ff, ox_in, oy_in;
   logic                          sat_ff, sat_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage 1: the four rotation products
   assign cx_in = PW'(trig.cos_val) * PW'(x0_ff);
   assign sy_in = PW'(trig.sin_val) * PW'(y0_ff);
   assign sx_in = PW'(trig.sin_val) * PW'(x0_ff);
   assign cy_in = PW'(trig.cos_val) * PW'(y0_ff);

   // stage 2: floor((sum + half) / 2^16)
   assign rx_sum = (PW + 1)'(cx_ff) - (PW + 1)'(sy_ff) + ROUND_HALF;
   assign ry_sum = (PW + 1)'(sx_ff) + (PW + 1)'(cy_ff) + ROUND_HALF;

   // stage 3: translate and clip
   assign tx_sum = SW'(rx_ff) + SW'(pose_x);
   assign ty_sum = SW'(ry_ff) + SW'(pose_y);

   always_comb begin
      sat_in = 1'b0;
      if (tx_sum > COORD_MAX) begin
         ox_in  = COORD_MAX[COORD_WIDTH-1:0];
         sat_in = 1'b1;
      end else if (tx_sum < COORD_MIN) begin
         ox_in  = COORD_MIN[COORD_WIDTH-1:0];
         sat_in = 1'b1;
      end else begin
         ox_in  = tx_sum[COORD_WIDTH-1:0];
      end
      if (ty_sum > COORD_MAX) begin
         oy_in  = COORD_MAX[COORD_WIDTH-1:0];
         sat_in = 1'b1;
      end else if (ty_sum < COORD_MIN) begin
         oy_in  = COORD_MIN[COORD_WIDTH-1:0];
         sat_in = 1'b1;
      end else begin
         oy_in  = ty_sum[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         x0_ff <= in_x;
         y0_ff <= in_y;
         a0_ff <= in_angle;
      end
      if (rdy1) begin
         cx_ff <= cx_in;
         sy_ff <= sy_in;
         sx_ff <= sx_in;
         cy_ff <= cy_in;
         // binary angle wraps on its own
         a1_ff <= a0_ff + pose_heading;
      end
      if (rdy2) begin
         rx_ff <= rx_sum[PW:se2pt_pkg::FRAC_W];
         ry_ff <= ry_sum[PW:se2pt_pkg::FRAC_W];
         a2_ff <= a1_ff;
      end
      if (rdy3) begin
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         sat_ff <= sat_in;
         a3_ff  <= a2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_angle = a3_ff;
   assign saturated = sat_ff;

endmodule

// ----- sv/se2_pose_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// se2_pose_transform
// Rotates each point by the configured heading, adds the translation with
// saturation, and adds the heading to the item's binary angle.
// ----------------------------------------------------------------------------
// items pass the four-stage pipeline of input register, rotation products,
//   rounding and clipping; throughput one item/cycle unless stalled by rsp_tready
// a heading write keeps the trig unit busy for two six-step horner passes on
//   one shared multiplier; req_tready and csr_ready are low then
// reset: pose zero, cos = 1.0, sin = 0, pipeline and trig unit empty
module se2_pose_transform #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // in_x, in_y, in_angle
   input  logic [((2*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // out_x, out_y, out_angle
   output logic [((2*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [se2pt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] csr_data
);

   localparam int FIELD_W = 2 * COORD_WIDTH + ANGLE_WIDTH;
   localparam int REQ_W   = ((FIELD_W + 7) / 8) * 8;
   localparam int PAD_W   = REQ_W - FIELD_W;

   logic signed [COORD_WIDTH-1:0] pose_x_ff, pose_y_ff;
   logic [ANGLE_WIDTH-1:0]        pose_heading_ff;
   logic                          csr_fire;
   logic                          trig_start;
   se2pt_pkg::trig_type           trig;
   logic                          dp_ready;
   logic signed [COORD_WIDTH-1:0] out_x, out_y;
   logic [ANGLE_WIDTH-1:0]        out_angle;

   assign csr_ready  = !trig.busy;
   assign csr_fire   = csr_valid && csr_ready;
   assign trig_start = csr_fire && (csr_index == se2pt_pkg::CSR_POSE_HEADING);

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff       <= '0;
         pose_y_ff       <= '0;
         pose_heading_ff <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            se2pt_pkg::CSR_POSE_X:       pose_x_ff       <= csr_data[COORD_WIDTH-1:0];
            se2pt_pkg::CSR_POSE_Y:       pose_y_ff       <= csr_data[COORD_WIDTH-1:0];
            se2pt_pkg::CSR_POSE_HEADING: pose_heading_ff <= csr_data[ANGLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   se2pt_trig #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_trig (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .heading (csr_data[ANGLE_WIDTH-1:0]),
      .trig    (trig)
   );

   // no items while the trig cache is being refreshed
   assign req_tready = dp_ready && !trig.busy;

   se2pt_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid && !trig.busy),
      .in_ready     (dp_ready),
      .in_x         (req_tdata[COORD_WIDTH-1:0]),
      .in_y         (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .in_angle     (req_tdata[FIELD_W-1:2*COORD_WIDTH]),
      .pose_x       (pose_x_ff),
      .pose_y       (pose_y_ff),
      .pose_heading (pose_heading_ff),
      .trig         (trig),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_x        (out_x),
      .out_y        (out_y),
      .out_angle    (out_angle),
      .saturated    (rsp_tuser)
   );

   generate
      if (PAD_W > 0) begin : g_pad
         assign rsp_tdata = {{PAD_W{1'b0}}, out_angle, out_y, out_x};
      end else begin : g_nopad
         assign rsp_tdata = {out_angle, out_y, out_x};
      end
   endgenerate

endmodule
